@@ design/skf_pkg.sv @@
// shared widths, constants, register indexes and types for the scalar kalman filter
package skf_pkg;

  // field widths
  localparam int MEAS_W     = 15;
  localparam int EST_W      = 15;
  localparam int ERR_W      = 20;
  localparam int GAIN_W     = 17;
  localparam int DEN_W      = ERR_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // default window length in samples
  localparam int WINDOW_DEF = 50;

  // estimate range, signed q7.8
  localparam logic signed [EST_W-1:0] EST_MIN = -15'sd10240;
  localparam logic signed [EST_W-1:0] EST_MAX = 15'sd10240;

  // unity gain in q1.16
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ERR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_ERR = 2'd2;

  // register reset values
  localparam logic signed [EST_W-1:0] INIT_EST_RST = 15'sd5120;
  localparam logic [ERR_W-1:0]        INIT_ERR_RST = 20'd65536;
  localparam logic [ERR_W-1:0]        MEAS_ERR_RST = 20'd2163;

  // controller to datapath commands
  typedef struct packed {
    logic reload;
    logic div_init;
    logic div_step;
    logic mul;
    logic update;
    logic out_load;
    logic last;
  } skf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic den_zero;
  } skf_sts_t;

  // saturate a wide signed value into the estimate range
  function automatic logic signed [EST_W-1:0] clamp_est(input logic signed [19:0] v);
    logic signed [EST_W-1:0] res;
    if (v < 20'(EST_MIN)) begin
      res = EST_MIN;
    end else if (v > 20'(EST_MAX)) begin
      res = EST_MAX;
    end else begin
      res = v[EST_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ design/skf_if.sv @@
// valid/ready channel interfaces for measurements and filtered results

interface skf_meas_if;
  import skf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [MEAS_W-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

interface skf_res_if;
  import skf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] estimate;
  logic [GAIN_W-1:0]       gain;
  logic                    window_end;

  modport source (output valid, output estimate, output gain, output window_end, input ready);
  modport sink (input valid, input estimate, input gain, input window_end, output ready);
endinterface

@@ design/skf_ctrl.sv @@
// controller: sequences a reload, or gain division, multiply and update, and the output load for each sample
module skf_ctrl #(
  parameter int WINDOW = skf_pkg::WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  skf_pkg::skf_sts_t sts,
  output skf_pkg::skf_cmd_t cmd
);
  import skf_pkg::*;

  localparam int PosW = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam int CntW = $clog2(GAIN_W);
  localparam logic [PosW-1:0] LastPos  = PosW'(WINDOW - 1);
  localparam logic [CntW-1:0] DivSteps = CntW'(GAIN_W - 1);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_UPD, S_FIN} state_t;

  state_t          state_r, state_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            in_xfer;
  logic            last;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign in_xfer   = in_valid && in_ready;
  assign last      = (pos_r == LastPos);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.last      = last;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (pos_r == '0) begin
            // window start: reload estimate and error
            cmd.reload = 1'b1;
            state_nxt  = S_FIN;
          end else begin
            cmd.div_init = 1'b1;
            if (sts.den_zero) begin
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_DIV;
              cnt_nxt   = DivSteps;
            end
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          pos_nxt       = last ? '0 : pos_r + 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/skf_dp.sv @@
// datapath: config registers, filter state, bit-serial gain divider, multipliers, output register
module skf_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [skf_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [skf_pkg::MEAS_W-1:0]     measurement,
  input  skf_pkg::skf_cmd_t                     cmd,
  output skf_pkg::skf_sts_t                     sts,
  output logic signed [skf_pkg::EST_W-1:0]      estimate,
  output logic [skf_pkg::GAIN_W-1:0]            gain,
  output logic                                  window_end
);
  import skf_pkg::*;

  // configuration registers
  logic signed [EST_W-1:0] init_est_r;
  logic [ERR_W-1:0]        init_err_r;
  logic [ERR_W-1:0]        meas_err_r;

  // filter state
  logic signed [EST_W-1:0]  est_r;
  logic [ERR_W-1:0]         err_r;
  logic signed [MEAS_W-1:0] z_r;

  // divider
  logic [DEN_W-1:0]  den;
  logic [36:0]       num;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [GAIN_W-1:0] num_lo_r;
  logic [GAIN_W-1:0] q_r;
  logic [DEN_W:0]    trial;
  logic              trial_ge;

  // multiply and update
  logic signed [17:0] gain_s;
  logic signed [16:0] diff;
  logic signed [34:0] pe_mul;
  logic [GAIN_W-1:0]  one_minus_g;
  logic [36:0]        pr_mul;
  logic signed [34:0] pe_r;
  logic [36:0]        pr_r;
  logic signed [34:0] pe_rnd;
  logic signed [18:0] delta;
  logic signed [19:0] est_sum;
  logic [37:0]        pr_rnd;

  // output register payload
  logic signed [EST_W-1:0] out_est_r;
  logic [GAIN_W-1:0]       out_gain_r;
  logic                    out_end_r;

  // denominator and rounded numerator of the gain division
  assign den          = {1'b0, err_r} + {1'b0, meas_err_r};
  assign num          = {1'b0, err_r, 16'b0} + 37'(den[DEN_W-1:1]);
  assign sts.den_zero = (den == '0);

  // one restoring division step
  assign trial    = {rem_r, num_lo_r[GAIN_W-1]};
  assign trial_ge = (trial >= {1'b0, den_r});

  // products
  assign gain_s      = $signed({1'b0, q_r});
  assign diff        = {{2{z_r[MEAS_W-1]}}, z_r} - {{2{est_r[EST_W-1]}}, est_r};
  assign pe_mul      = gain_s * diff;
  assign one_minus_g = GAIN_ONE - q_r;
  assign pr_mul      = err_r * one_minus_g;

  // rounding and saturating update
  assign pe_rnd  = pe_r + 35'sd32768;
  assign delta   = pe_rnd[34:16];
  assign est_sum = {{5{est_r[EST_W-1]}}, est_r} + {delta[18], delta};
  assign pr_rnd  = {1'b0, pr_r} + 38'd32768;

  assign estimate   = out_est_r;
  assign gain       = out_gain_r;
  assign window_end = out_end_r;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_est_r <= INIT_EST_RST;
      init_err_r <= INIT_ERR_RST;
      meas_err_r <= MEAS_ERR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INIT_EST: init_est_r <= $signed(cfg_data[EST_W-1:0]);
        CFG_INIT_ERR: init_err_r <= cfg_data[ERR_W-1:0];
        CFG_MEAS_ERR: meas_err_r <= cfg_data[ERR_W-1:0];
        default: ;
      endcase
    end
  end

  // estimate and error state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
      err_r <= '0;
    end else if (cmd.reload) begin
      est_r <= clamp_est({{5{init_est_r[EST_W-1]}}, init_est_r});
      err_r <= init_err_r;
    end else if (cmd.update) begin
      est_r <= clamp_est(est_sum);
      err_r <= pr_rnd[35:16];
    end
  end

  // divider, products and measurement capture
  always_ff @(posedge clk) begin
    if (cmd.reload) begin
      q_r <= '0;
    end else if (cmd.div_init) begin
      z_r      <= measurement;
      den_r    <= den;
      rem_r    <= {1'b0, num[36:17]};
      num_lo_r <= num[16:0];
      q_r      <= '0;
    end else if (cmd.div_step) begin
      rem_r    <= trial_ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      num_lo_r <= {num_lo_r[GAIN_W-2:0], 1'b0};
      q_r      <= {q_r[GAIN_W-2:0], trial_ge};
    end
    if (cmd.mul) begin
      pe_r <= pe_mul;
      pr_r <= pr_mul;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_est_r  <= est_r;
      out_gain_r <= q_r;
      out_end_r  <= cmd.last;
    end
  end

endmodule

@@ design/scalar_kalman_filter.sv @@
// top level of the scalar kalman filter: controller, datapath and checks
//
// One-dimensional Kalman filter over signed Q7.8 temperature samples, one result per
// sample. Samples form windows of WINDOW samples; the first of a window reloads the
// estimate and error from the configuration registers and reports gain 0. A regular
// sample passes, after its transfer, through the bit-serial divider forming the Q1.16
// gain, a multiply state, the rounding and saturating update and the output load,
// which waits until the output register is free. A window-start sample, or one whose
// gain denominator is zero, goes from its transfer straight to the output load. The
// next sample is taken once the output load is done, while the previous result may
// still wait in the output register.
// Configuration registers are written through cfg_we, cfg_index and cfg_data.
module scalar_kalman_filter #(
  parameter int WINDOW = skf_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skf_pkg::CFG_DATA_W-1:0] cfg_data,
  skf_meas_if.sink                       in_meas,
  skf_res_if.source                      out_res
);
  import skf_pkg::*;

  skf_cmd_t cmd;
  skf_sts_t sts;

  // sequencing
  skf_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_meas.valid),
    .in_ready  (in_meas.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and storage
  skf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .measurement (in_meas.measurement),
    .cmd         (cmd),
    .sts         (sts),
    .estimate    (out_res.estimate),
    .gain        (out_res.gain),
    .window_end  (out_res.window_end)
  );

  // no new sample is taken in the cycle after a transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_meas.valid && in_meas.ready) |=> !in_meas.ready)
    else $error("input ready right after a transfer");

  // the gain never exceeds unity
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.gain <= GAIN_ONE))
    else $error("gain above unity");

  // the estimate stays saturated
  a_est_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (($signed(out_res.estimate) >= EST_MIN) &&
                       ($signed(out_res.estimate) <= EST_MAX)))
    else $error("estimate out of range");

endmodule

@@ tb/tb_scalar_kalman_filter.sv @@
// self-checking testbench for the scalar kalman filter: directed table, random windows
`timescale 1ns / 100ps

module tb_scalar_kalman_filter;
  import skf_pkg::*;

  localparam int  WINDOW        = WINDOW_DEF;
  localparam int  RANDOM_ITEMS  = 1200;
  localparam int  SETTLE_CYCLES = 24;
  localparam int  STEADY_FROM   = 600;
  localparam int  STEADY_TO     = 850;
  localparam int  HOLD_AT       = 1000;
  localparam int  HOLD_CYCLES   = 400;
  localparam longint UNITY      = 65536;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [EST_W-1:0] estimate;
    logic [GAIN_W-1:0]       gain;
    logic                    window_end;
  } filt_res_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_FLUSH} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    data;
    logic signed [MEAS_W-1:0] z;
    logic                     typed;
    filt_res_t                typed_res;
  } row_t;

  // directed table: typed results only where they follow directly from the registers
  localparam row_t DIR_ROWS [25] = '{
    // reset settings, window start reloads 20.0 degrees
    '{ROW_ITEM,  CFG_SPARE,    20'h0,     15'sd0,      1'b1, '{15'sd5120,   17'd0, 1'b0}},
    '{ROW_ITEM,  CFG_SPARE,    20'h0,     15'sd10240,  1'b0, '0},
    '{ROW_ITEM,  CFG_SPARE,    20'h0,     -15'sd10240, 1'b0, '0},
    '{ROW_ITEM,  CFG_SPARE,    20'h0,     15'h3FFF,    1'b0, '0},
    '{ROW_ITEM,  CFG_SPARE,    20'h0,     15'h4000,    1'b0, '0},
    '{ROW_FLUSH, CFG_SPARE,    20'h0,     15'sd0,      1'b0, '0},
    // out of range initial estimate, zero error and zero variance
    '{ROW_CFG,   CFG_INIT_EST, 20'h03FFF, 15'sd0,      1'b0, '0},
    '{ROW_CFG,   CFG_INIT_ERR, 20'h00000, 15'sd0,      1'b0, '0},
    '{ROW_CFG,   CFG_MEAS_ERR, 20'h00000, 15'sd0,      1'b0, '0},
    '{ROW_CFG,   CFG_SPARE,    20'hFFFFF, 15'sd0,      1'b0, '0},
    '{ROW_ITEM,  CFG_SPARE,    20'h0,     15'h4000,    1'b1, '{15'sd10240,  17'd0, 1'b0}},
    '{ROW_ITEM,  CFG_SPARE,    20'h0,     15'h4000,    1'b1, '{15'sd10240,  17'd0, 1'b0}},
    '{ROW_FLUSH, CFG_SPARE,    20'h0,     15'sd0,      1'b0, '0},
    // most negative estimate register, largest error: unity gain then collapse
    '{ROW_CFG,   CFG_INIT_EST, 20'h04000, 15'sd0,      1'b0, '0},
    '{ROW_CFG,   CFG_INIT_ERR, 20'hFFFFF, 15'sd0,      1'b0, '0},
    '{ROW_ITEM,  CFG_SPARE,    20'h0,     15'sd0,      1'b1, '{-15'sd10240, 17'd0, 1'b0}},
    '{ROW_ITEM,  CFG_SPARE,    20'h0,     15'sd10240,  1'b1,
      '{15'sd10240, 17'h10000, 1'b0}},
    '{ROW_ITEM,  CFG_SPARE,    20'h0,     15'h4000,    1'b1, '{15'sd10240,  17'd0, 1'b0}},
    '{ROW_FLUSH, CFG_SPARE,    20'h0,     15'sd0,      1'b0, '0},
    // largest variance against the smallest error
    '{ROW_CFG,   CFG_MEAS_ERR, 20'hFFFFF, 15'sd0,      1'b0, '0},
    '{ROW_CFG,   CFG_INIT_ERR, 20'h00001, 15'sd0,      1'b0, '0},
    '{ROW_CFG,   CFG_INIT_EST, 20'h00000, 15'sd0,      1'b0, '0},
    '{ROW_ITEM,  CFG_SPARE,    20'h0,     15'sd10240,  1'b1, '{15'sd0,      17'd0, 1'b0}},
    '{ROW_ITEM,  CFG_SPARE,    20'h0,     15'sd10240,  1'b0, '0},
    '{ROW_FLUSH, CFG_SPARE,    20'h0,     15'sd0,      1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  skf_meas_if meas_ch();
  skf_res_if  res_ch();

  scalar_kalman_filter #(.WINDOW(WINDOW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_meas   (meas_ch),
    .out_res   (res_ch)
  );

  // filter state mirrored by the testbench
  logic signed [EST_W-1:0] init_est_r = INIT_EST_RST;
  logic [ERR_W-1:0]        init_err_r = INIT_ERR_RST;
  logic [ERR_W-1:0]        meas_err_r = MEAS_ERR_RST;
  longint                  est_q      = 0;
  longint                  err_q      = 0;
  int                      win_pos    = 0;

  filt_res_t pending_results[$];

  int  sent_items    = 0;
  int  results_seen  = 0;
  int  fail_count    = 0;
  int  cfg_settings  = 0;
  int  windows_done  = 0;
  int  zero_den_hits = 0;
  int  sat_hits      = 0;
  bit  hold_done     = 0;
  logic steady;

  // no random idling on either side through one stretch of the run
  assign steady = (sent_items >= STEADY_FROM) && (sent_items < STEADY_TO);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("scalar_kalman_filter verification failed");
    $finish;
  end

  function automatic longint clamp_temp(input longint v);
    if (v < longint'(EST_MIN)) return longint'(EST_MIN);
    if (v > longint'(EST_MAX)) return longint'(EST_MAX);
    return v;
  endfunction

  // one filter step: reload at window start, else gain, estimate and error update unless the denominator is zero
  function automatic filt_res_t filter_step(input logic signed [MEAS_W-1:0] z);
    filt_res_t r;
    longint    err;
    longint    den;
    longint    g;
    longint    delta;
    longint    sum;
    r.gain = '0;
    if (win_pos == 0) begin
      est_q = clamp_temp(longint'(init_est_r));
      err_q = longint'(init_err_r);
    end else begin
      err = err_q;
      den = err + longint'(meas_err_r);
      if (den != 0) begin
        g = (err * UNITY + den / 2) / den;
        if (g > UNITY) g = UNITY;
        delta = (g * (longint'(z) - est_q) + 32768) >>> 16;
        sum = est_q + delta;
        if (clamp_temp(sum) != sum) sat_hits++;
        est_q = clamp_temp(sum);
        err_q = ((err * (UNITY - g) + 32768) >> 16) & 64'hFFFFF;
        r.gain = g[GAIN_W-1:0];
      end else begin
        zero_den_hits++;
      end
    end
    r.estimate   = est_q[EST_W-1:0];
    r.window_end = (win_pos + 1 >= WINDOW);
    if (r.window_end) begin
      win_pos = 0;
      windows_done++;
    end else begin
      win_pos++;
    end
    return r;
  endfunction

  // offer one measurement, idling at random first outside the steady stretch; predict once it transfers
  task automatic send_sample(input logic signed [MEAS_W-1:0] z, input logic typed,
                             input filt_res_t typed_res);
    filt_res_t pred;
    while (!steady && $urandom_range(0, 99) < 30) begin
      meas_ch.valid <= 1'b0;
      @(posedge clk);
    end
    meas_ch.valid       <= 1'b1;
    meas_ch.measurement <= z;
    do @(posedge clk); while (!meas_ch.ready);
    sent_items++;
    pred = filter_step(z);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // stop offering and wait until every result is back and the block is quiet
  task automatic wait_drained();
    meas_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_INIT_EST: init_est_r = data[EST_W-1:0];
      CFG_INIT_ERR: init_err_r = data;
      CFG_MEAS_ERR: meas_err_r = data;
      default: ;
    endcase
  endtask

  // random error or variance setting, extremes included
  function automatic logic [CFG_DATA_W-1:0] pick_error();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'($urandom_range(0, 255));
      3:       return CFG_DATA_W'($urandom_range(0, 8191));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // result side: check each transfer, ready at random, one long hold-off
  initial begin : result_sink
    int        hold_left;
    filt_res_t want;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no sample pending: estimate %0d gain %0d",
                 res_ch.estimate, res_ch.gain);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          results_seen++;
          if (res_ch.estimate !== want.estimate) begin
            $error("estimate: expected %0d, got %0d", want.estimate, res_ch.estimate);
            fail_count++;
          end
          if (res_ch.gain !== want.gain) begin
            $error("gain: expected %0d, got %0d", want.gain, res_ch.gain);
            fail_count++;
          end
          if (res_ch.window_end !== want.window_end) begin
            $error("window_end: expected %0d, got %0d", want.window_end, res_ch.window_end);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= steady || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // measurement side: reset, directed table, random windows, then the verdict
  initial begin : stimulus
    int                       rand_done;
    int                       n;
    int                       centre;
    int                       v;
    logic signed [MEAS_W-1:0] z;
    rand_done = 0;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_SPARE;
    cfg_data            <= '0;
    meas_ch.valid       <= 1'b0;
    meas_ch.measurement <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (DIR_ROWS[i]) begin
      case (DIR_ROWS[i].kind)
        ROW_CFG: begin
          wait_drained();
          write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
        end
        ROW_FLUSH: begin
          while (win_pos != 0) begin
            v = int'($urandom_range(0, 20480)) - 10240;
            send_sample(MEAS_W'(v), 1'b0, '0);
          end
        end
        default: send_sample(DIR_ROWS[i].z, DIR_ROWS[i].typed, DIR_ROWS[i].typed_res);
      endcase
    end
    cfg_settings = 4;

    // random phases: fresh settings, then WINDOW to 3*WINDOW samples, mostly around one temperature
    while (rand_done < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0:       v = 16383;
        1:       v = -16384;
        2:       v = 10240;
        3:       v = -10240;
        default: v = int'($urandom_range(0, 20480)) - 10240;
      endcase
      write_reg(CFG_INIT_EST, CFG_DATA_W'(v));
      write_reg(CFG_INIT_ERR, pick_error());
      write_reg(CFG_MEAS_ERR, pick_error());
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
      cfg_settings++;
      centre = int'($urandom_range(0, 20480)) - 10240;
      n = $urandom_range(WINDOW, 3 * WINDOW);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0:       v = int'($urandom);
          1, 2:    v = int'($urandom_range(0, 20480)) - 10240;
          default: v = centre + int'($urandom_range(0, 1024)) - 512;
        endcase
        z = MEAS_W'(v);
        send_sample(z, 1'b0, '0);
        rand_done++;
      end
    end

    wait_drained();
    $display("covered %0d samples over %0d windows under %0d register settings",
             sent_items, windows_done, cfg_settings);
    $display("%0d zero-denominator steps, %0d saturated estimates, %0d results checked",
             zero_den_hits, sat_hits, results_seen);
    if (fail_count == 0) begin
      $display("scalar_kalman_filter verification clean");
    end else begin
      $display("scalar_kalman_filter verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/skf_pkg.sv
design/skf_if.sv
design/skf_ctrl.sv
design/skf_dp.sv
design/scalar_kalman_filter.sv
tb/tb_scalar_kalman_filter.sv
